[rtl/swm_pkg.sv]
// Package for the scope wildcard matcher: request and result types
// and the character codes that the matcher recognizes. No dependencies.
`timescale 1ns / 1ps

package swm_pkg;

	// One request: a pattern byte to load or a value byte to match.
	typedef struct packed {
		logic       func;
		logic [7:0] char_code;
	} item_t;

	// One result, given when a value's terminating zero byte arrives.
	typedef struct packed {
		logic matched;
		logic pattern_too_long;
	} result_t;

	// Request kinds carried in the func field.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_MATCH = 1'b1;

	// Characters with a special meaning in a pattern.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_HASH  = 8'h23;

endpackage

[rtl/swm_match_core.sv]
// Matching core of the scope wildcard matcher: pattern store, pattern
// state and the per-byte match step. Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_match_core #(
	parameter int PATTERN_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  swm_pkg::item_t   item,
	output logic             res_valid,
	output swm_pkg::result_t res
);
	import swm_pkg::*;

	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int AW = $clog2(PATTERN_MAX);

	// Pattern store; the read data register always holds the entry at the pointer.
	logic [7:0] mem [PATTERN_MAX];
	logic [7:0] rd_q;

	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] ptr_q, ptr_d;
	logic          load_open_q, load_open_d;
	logic          eml_q, eml_d;
	logic          ovf_q, ovf_d;
	logic          skip_q, skip_d;
	logic          started_q, started_d;
	logic          decided_q, decided_d;
	logic          dres_q, dres_d;
	logic [7:0]    last_q, last_d;
	logic [7:0]    prev_q, prev_d;

	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          whole_ml;
	logic          at_tail;
	logic          go;

	// A pattern of exactly "/#" accepts any non-empty value.
	assign whole_ml = eml_q && (len_q == LW'(2));
	// The pointer sits on the trailing "/#" of the pattern.
	assign at_tail  = eml_q && (({1'b0, ptr_q} + (LW + 1)'(2)) == {1'b0, len_q});

	// Next-state logic for one request.
	always_comb begin
		len_d       = len_q;
		ptr_d       = ptr_q;
		load_open_d = load_open_q;
		eml_d       = eml_q;
		ovf_d       = ovf_q;
		skip_d      = skip_q;
		started_d   = started_q;
		decided_d   = decided_q;
		dres_d      = dres_q;
		last_d      = last_q;
		prev_d      = prev_q;
		we          = 1'b0;
		waddr       = len_q[AW-1:0];
		go          = 1'b0;
		res_valid   = 1'b0;
		res         = '0;
		if (en) begin
			if (item.func == FUNC_LOAD) begin
				// Any pattern byte abandons a value in progress.
				ptr_d     = '0;
				skip_d    = 1'b0;
				started_d = 1'b0;
				decided_d = 1'b0;
				dres_d    = 1'b0;
				if (!load_open_q) begin
					len_d = '0;
					ovf_d = 1'b0;
					eml_d = 1'b0;
				end
				if (item.char_code != CH_NUL) begin
					load_open_d = 1'b1;
					if (len_d < LW'(PATTERN_MAX)) begin
						we     = 1'b1;
						waddr  = len_d[AW-1:0];
						len_d  = len_d + LW'(1);
						prev_d = last_q;
						last_d = item.char_code;
					end else begin
						ovf_d = 1'b1;
					end
				end else begin
					load_open_d = 1'b0;
					eml_d = !ovf_d && (len_d >= LW'(2)) &&
						(prev_q == CH_SLASH) && (last_q == CH_HASH);
				end
			end else if (item.char_code != CH_NUL) begin
				started_d = 1'b1;
				if (!decided_q && !whole_ml) begin
					// Inside a '+' level, bytes up to the next slash are skipped.
					go = 1'b1;
					if (skip_q) begin
						if (item.char_code != CH_SLASH) begin
							go = 1'b0;
						end else begin
							skip_d = 1'b0;
						end
					end
					if (go) begin
						priority if (at_tail) begin
							decided_d = 1'b1;
							dres_d    = (item.char_code == CH_SLASH);
						end else if (ptr_q >= len_q) begin
							decided_d = 1'b1;
							dres_d    = 1'b0;
						end else if (rd_q == CH_PLUS) begin
							if (item.char_code == CH_SLASH) begin
								decided_d = 1'b1;
								dres_d    = 1'b0;
							end else begin
								skip_d = 1'b1;
								ptr_d  = ptr_q + LW'(1);
							end
						end else if (rd_q != item.char_code) begin
							decided_d = 1'b1;
							dres_d    = 1'b0;
						end else begin
							ptr_d = ptr_q + LW'(1);
						end
					end
				end
			end else begin
				// End of the value: give the result and start over.
				res_valid            = 1'b1;
				res.pattern_too_long = ovf_q;
				priority if (ovf_q) begin
					res.matched = 1'b0;
				end else if (whole_ml) begin
					res.matched = started_q;
				end else if (decided_q) begin
					res.matched = dres_q;
				end else if (at_tail) begin
					res.matched = 1'b1;
				end else begin
					res.matched = (ptr_q == len_q);
				end
				ptr_d     = '0;
				skip_d    = 1'b0;
				started_d = 1'b0;
				decided_d = 1'b0;
				dres_d    = 1'b0;
			end
		end
	end

	assign raddr = ptr_d[AW-1:0];

	// Store write and read; a write to the address being read is forwarded.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= item.char_code;
		end
		if (we && (waddr == raddr)) begin
			rd_q <= item.char_code;
		end else begin
			rd_q <= mem[raddr];
		end
	end

	// Last two stored pattern bytes, used to spot a trailing "/#".
	always_ff @(posedge clk) begin
		last_q <= last_d;
		prev_q <= prev_d;
	end

	// Pattern and match state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ptr_q       <= '0;
			load_open_q <= 1'b0;
			eml_q       <= 1'b0;
			ovf_q       <= 1'b0;
			skip_q      <= 1'b0;
			started_q   <= 1'b0;
			decided_q   <= 1'b0;
			dres_q      <= 1'b0;
		end else begin
			len_q       <= len_d;
			ptr_q       <= ptr_d;
			load_open_q <= load_open_d;
			eml_q       <= eml_d;
			ovf_q       <= ovf_d;
			skip_q      <= skip_d;
			started_q   <= started_d;
			decided_q   <= decided_d;
			dres_q      <= dres_d;
		end
	end

endmodule

[rtl/scope_wildcard_matcher.sv]
// Top level of the scope wildcard matcher: request register, matching core
// and result register. Depends on swm_pkg and swm_match_core.
//
// Usage: requests arrive on item_valid / item_stall / item, one byte each.
// A request with func 0 loads a pattern byte; a zero byte closes the pattern.
// A request with func 1 streams a value byte; the value's zero byte yields
// one result on result_valid / result_stall / result. Other requests give
// no result.
// Path: a zero byte passes through the request register, then the result
// register, from which the receiver takes the result. Throughput is one
// request per cycle while no result is held under result_stall; the pattern
// store read for the next byte is issued in the same cycle that the current
// byte moves the pattern pointer.
// Stalls: while a result waits under result_stall, one more request is
// still taken into the request register; item_stall rises only when that
// register is full and the result register is blocked.
// Reset: arst_n clears all control state, the pattern becomes empty (it
// matches only the empty value) and no request or result is pending.
`timescale 1ns / 1ps

module scope_wildcard_matcher #(
	parameter int PATTERN_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  swm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output swm_pkg::result_t result
);
	import swm_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    proceed;
	logic    core_valid;
	result_t core_res;

	// The request register moves on whenever the result register can take data.
	assign proceed    = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !proceed;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	swm_match_core #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (valid_s1 && proceed),
		.item     (item_s1),
		.res_valid(core_valid),
		.res      (core_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (proceed) begin
			result_valid <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && core_valid) begin
			result <= core_res;
		end
	end

endmodule

[rtl/swm_checker.sv]
// Port-level checks for the scope wildcard matcher and the bind that
// attaches them to the top level. Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input swm_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input swm_pkg::result_t result
);
	import swm_pkg::*;

	// A blocked result stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// An overflowed pattern never reports a match.
	a_overflow_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.matched && result.pattern_too_long))
		else $error("match reported against an overflowed pattern");

	// Requests are held back only while a result is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("request stalled without a blocked result");

	// A fresh result must trace back to an accepted zero byte of a value.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall &&
			(item.func == FUNC_MATCH) && (item.char_code == CH_NUL), 2))
		else $error("result without a terminating value byte");

endmodule

bind scope_wildcard_matcher swm_checker u_swm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.item        (item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
